// ===== rtl/core/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg
// Types and constants shared by the page frame bitmap allocator modules.
// ----------------------------------------------------------------------------
package pfba_pkg;

	// Width of a frame number on the request and result ports
	localparam int FRAME_NUM_W = 16;

	// Request commands
	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_CLAIM = 2'd2,
		CMD_TEST  = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_SKIP   = 2'd1,
		STAT_NOFREE = 2'd2
	} status_t;

	// Request payload
	typedef struct packed {
		cmd_t                   command;
		logic [FRAME_NUM_W-1:0] frame_number;
		logic                   page_present;
		logic                   kernel;
		logic                   writable;
	} req_t;

	// Result payload
	typedef struct packed {
		logic [FRAME_NUM_W-1:0] result_frame;
		logic                   entry_present;
		logic                   entry_writable;
		logic                   entry_user;
		logic                   frame_busy;
		status_t                status;
	} rsp_t;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_SPLIT,
		S_READ,
		S_APPLY,
		S_SCAN
	} state_t;

	// Bitmap write source
	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLEAR,
		WR_MODIFY,
		WR_FOUND
	} wr_sel_t;

	// Kind of result to register
	typedef enum logic [2:0] {
		RES_NONE,
		RES_SKIP,
		RES_NOFREE,
		RES_ALLOC,
		RES_APPLY
	} res_kind_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      clr_step;
		logic      load;
		logic      div;
		logic      split;
		logic      rd_word;
		logic      scan_start;
		logic      scan;
		wr_sel_t   write;
		res_kind_t finish;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		cmd_t command;
		logic page_present;
		logic skip;
		logic clr_last;
		logic hit;
		logic cand_ok;
		logic exhausted;
	} dp_stat_t;

endpackage

// ===== rtl/core/pfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfba_ctrl
// Sequencer for the allocator: clearing pass, request decode, word
// read-modify-write and the first-fit scan.
// ----------------------------------------------------------------------------
module pfba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pfba_pkg::dp_stat_t  stat,
	output pfba_pkg::ctrl_cmd_t cmd
);

	pfba_pkg::state_t state_q;
	pfba_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.write       = pfba_pkg::WR_NONE;
		cmd.finish      = pfba_pkg::RES_NONE;
		busy            = 1'b1;
		unique case (state_q)
			pfba_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.write    = pfba_pkg::WR_CLEAR;
				if (stat.clr_last) begin
					state_d = pfba_pkg::S_IDLE;
				end
			end
			pfba_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
				if (start) begin
					state_d = pfba_pkg::S_DIV;
				end
			end
			pfba_pkg::S_DIV: begin
				cmd.div = 1'b1;
				if (stat.command == pfba_pkg::CMD_ALLOC) begin
					if (stat.page_present) begin
						cmd.finish = pfba_pkg::RES_SKIP;
						state_d    = pfba_pkg::S_IDLE;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = pfba_pkg::S_SCAN;
					end
				end else begin
					state_d = pfba_pkg::S_SPLIT;
				end
			end
			pfba_pkg::S_SPLIT: begin
				cmd.split = 1'b1;
				if (stat.skip) begin
					cmd.finish = pfba_pkg::RES_SKIP;
					state_d    = pfba_pkg::S_IDLE;
				end else begin
					state_d = pfba_pkg::S_READ;
				end
			end
			pfba_pkg::S_READ: begin
				cmd.rd_word = 1'b1;
				state_d     = pfba_pkg::S_APPLY;
			end
			pfba_pkg::S_APPLY: begin
				cmd.finish = pfba_pkg::RES_APPLY;
				if (stat.command != pfba_pkg::CMD_TEST) begin
					cmd.write = pfba_pkg::WR_MODIFY;
				end
				state_d = pfba_pkg::S_IDLE;
			end
			pfba_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					if (stat.cand_ok) begin
						cmd.write  = pfba_pkg::WR_FOUND;
						cmd.finish = pfba_pkg::RES_ALLOC;
					end else begin
						// first clear bit lies past the last frame
						cmd.finish = pfba_pkg::RES_NOFREE;
					end
					state_d = pfba_pkg::S_IDLE;
				end else if (stat.exhausted) begin
					cmd.finish = pfba_pkg::RES_NOFREE;
					state_d    = pfba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pfba_pkg::S_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/core/pfba_dpath.sv =====
// ----------------------------------------------------------------------------
// pfba_dpath
// Bitmap memory, frame to word/bit split, scan pipeline and result register.
// ----------------------------------------------------------------------------
module pfba_dpath #(
	parameter int FRAME_COUNT = 65536,
	parameter int WORD_BITS   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfba_pkg::req_t      req,
	input  pfba_pkg::ctrl_cmd_t cmd,
	output pfba_pkg::dp_stat_t  stat,
	output logic                done,
	output pfba_pkg::rsp_t      rsp
);

	localparam int FNW        = pfba_pkg::FRAME_NUM_W;
	localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int CW         = $clog2(WORD_COUNT + 1);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int FW         = $clog2(WORD_COUNT * WORD_BITS + 1);
	// reciprocal for frame / WORD_BITS, exact for every FNW-bit frame
	localparam int DIV_S      = FNW + BIT_W;
	localparam int MUL_W      = FNW + 2;
	localparam longint unsigned DIV_M = ((64'd1 << DIV_S) / WORD_BITS) + 1;
	localparam logic [MUL_W-1:0] DIV_MC = MUL_W'(DIV_M);

	// Lowest clear bit of a word
	function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];

	pfba_pkg::req_t         item_q;
	logic [FNW-1:0]         q_q;
	logic [AW-1:0]          word_addr_q;
	logic [BIT_W-1:0]       bit_q;
	logic [CW-1:0]          clr_addr_q;
	logic [CW-1:0]          scan_addr_q;
	logic [FW-1:0]          base_q;
	logic                   scan_vld_s1;
	logic [AW-1:0]          addr_s1;
	logic [FW-1:0]          base_s1;
	logic [WORD_BITS-1:0]   rd_data_q;
	logic                   done_q;
	pfba_pkg::rsp_t         rsp_q;
	pfba_pkg::rsp_t         rsp_d;

	logic [FNW+MUL_W-1:0]   prod;
	logic [31:0]            q_ext;
	logic [31:0]            q_scaled;
	logic [FNW-1:0]         rem;
	logic                   in_range;
	logic                   scan_more;
	logic [BIT_W-1:0]       free_idx;
	logic [FW-1:0]          cand;
	logic [WORD_BITS-1:0]   bit_mask;
	logic [WORD_BITS-1:0]   free_mask;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [WORD_BITS-1:0]   wr_data;

	// Frame split arithmetic
	assign prod     = (FNW + MUL_W)'(item_q.frame_number) * (FNW + MUL_W)'(DIV_MC);
	assign q_ext    = 32'(q_q);
	assign q_scaled = q_ext * 32'(WORD_BITS);
	assign rem      = item_q.frame_number - q_scaled[FNW-1:0];
	assign in_range = 32'(item_q.frame_number) < 32'(FRAME_COUNT);

	// Scan check on the word read last cycle
	assign scan_more = scan_addr_q < CW'(WORD_COUNT);
	assign free_idx  = lowest_zero(rd_data_q);
	assign cand      = base_s1 + FW'(free_idx);
	assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_q;
	assign free_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << free_idx;

	// Status to the controller
	always_comb begin
		stat.command      = item_q.command;
		stat.page_present = item_q.page_present;
		stat.skip         = !in_range ||
			(item_q.command == pfba_pkg::CMD_FREE && item_q.frame_number == '0);
		stat.clr_last     = clr_addr_q == CW'(WORD_COUNT - 1);
		stat.hit          = scan_vld_s1 && rd_data_q != '1;
		stat.cand_ok      = 32'(cand) < 32'(FRAME_COUNT);
		stat.exhausted    = !scan_vld_s1 && !scan_more;
	end

	// Request capture and frame split
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.div) begin
			q_q <= FNW'(prod >> DIV_S);
		end
		if (cmd.split) begin
			word_addr_q <= q_ext[AW-1:0];
			bit_q       <= rem[BIT_W-1:0];
		end
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= clr_addr_q + CW'(1);
		end
	end

	// Scan address generator and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan && scan_more;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_addr_q <= '0;
			base_q      <= '0;
		end else if (cmd.scan && scan_more) begin
			scan_addr_q <= scan_addr_q + CW'(1);
			base_q      <= base_q + FW'(WORD_BITS);
		end
		if (cmd.scan && scan_more) begin
			addr_s1 <= scan_addr_q[AW-1:0];
			base_s1 <= base_q;
		end
	end

	// Bitmap read port
	assign rd_en   = cmd.rd_word || (cmd.scan && scan_more);
	assign rd_addr = cmd.rd_word ? word_addr_q : scan_addr_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= bitmap_mem[rd_addr];
		end
	end

	// Bitmap write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (cmd.write)
			pfba_pkg::WR_NONE: begin
			end
			pfba_pkg::WR_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q[AW-1:0];
			end
			pfba_pkg::WR_MODIFY: begin
				wr_en   = 1'b1;
				wr_addr = word_addr_q;
				wr_data = (item_q.command == pfba_pkg::CMD_FREE) ?
					(rd_data_q & ~bit_mask) : (rd_data_q | bit_mask);
			end
			pfba_pkg::WR_FOUND: begin
				wr_en   = 1'b1;
				wr_addr = addr_s1;
				wr_data = rd_data_q | free_mask;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bitmap_mem[wr_addr] <= wr_data;
		end
	end

	// Result formation
	always_comb begin
		rsp_d        = '0;
		rsp_d.status = pfba_pkg::STAT_DONE;
		unique case (cmd.finish)
			pfba_pkg::RES_NONE: begin
			end
			pfba_pkg::RES_SKIP: begin
				rsp_d.status = pfba_pkg::STAT_SKIP;
			end
			pfba_pkg::RES_NOFREE: begin
				rsp_d.status = pfba_pkg::STAT_NOFREE;
			end
			pfba_pkg::RES_ALLOC: begin
				rsp_d.result_frame   = FNW'(cand);
				rsp_d.entry_present  = 1'b1;
				rsp_d.entry_writable = item_q.writable;
				rsp_d.entry_user     = !item_q.kernel;
			end
			pfba_pkg::RES_APPLY: begin
				case (item_q.command)
					pfba_pkg::CMD_CLAIM: begin
						rsp_d.result_frame   = item_q.frame_number;
						rsp_d.entry_present  = 1'b1;
						rsp_d.entry_writable = item_q.writable;
						rsp_d.entry_user     = !item_q.kernel;
					end
					pfba_pkg::CMD_TEST: begin
						rsp_d.frame_busy = rd_data_q[bit_q];
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Result register: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish != pfba_pkg::RES_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish != pfba_pkg::RES_NONE) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// An allocation only writes back a word that had a clear bit
	a_found_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write == pfba_pkg::WR_FOUND |-> scan_vld_s1 && rd_data_q != '1)
		else $error("allocation wrote a full bitmap word");

	// No read is tracked once the scan has run past the last word
	a_scan_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan && !scan_more |=> !scan_vld_s1)
		else $error("scan read past the last bitmap word");

endmodule

// ===== rtl/core/page_frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit page frame allocator over a bitmap of used frames.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; its result is
// shown on rsp for exactly one cycle with done high, and the receiver must
// take it then. After reset the block clears its bitmap, one word per cycle,
// so busy stays high until all WORD_COUNT = ceil(FRAME_COUNT / WORD_BITS)
// words (2048 by default) are cleared. Allocate reads one bitmap word per
// cycle from the memory's single read port: its scan stops at the first
// word with a clear bit and runs over every word when every frame is used.
// Free and claim do one read-modify-write of a word, and test only reads
// the word; an allocate on a page already present is answered from the
// divide step and any other skipped request from the split step. A new
// request may be transferred in the cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator #(
	parameter int FRAME_COUNT = 65536,
	parameter int WORD_BITS   = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pfba_pkg::req_t req,
	output logic           done,
	output pfba_pkg::rsp_t rsp
);

	pfba_pkg::ctrl_cmd_t cmd;
	pfba_pkg::dp_stat_t  stat;

	// Controller
	pfba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Datapath
	pfba_dpath #(
		.FRAME_COUNT (FRAME_COUNT),
		.WORD_BITS   (WORD_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

	// A result is only shown while the block is ready for the next request
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// No result in the cycle right after a transfer
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result one cycle after transfer");

	// A used-frame report carries no page entry
	a_test_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.frame_busy |-> rsp.status == pfba_pkg::STAT_DONE && !rsp.entry_present)
		else $error("test result mixed with page entry");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit page frame bitmap allocator. Requests
// are driven in random bursts. A frame ledger inside the bench mirrors the
// bitmap to predict every result, and each strobed result is compared field by
// field. The run covers a directed pass on an empty map and random traffic
// mostly over a small frame window and recently granted frames.
// ----------------------------------------------------------------------------
module testbench;

	localparam int FRAME_COUNT = 65536;
	localparam int WORD_BITS   = 32;
	localparam int WORD_COUNT  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int RANDOM_ITEMS = 268;
	// Longest quiet stretch: clearing pass or a full scan, plus sender gaps
	localparam int STALL_LIMIT = 4 * (WORD_COUNT + 64);

	// Frame ledger: mirror of the bitmap plus the queue of pending results
	class frame_ledger;
		bit [WORD_BITS-1:0] used_words [WORD_COUNT];
		pfba_pkg::rsp_t expected_results[$];
		int unsigned granted_frames[$];
		int unsigned errors;

		function new();
			foreach (used_words[w])
				used_words[w] = '0;
			errors = 0;
		endfunction

		// Lowest free frame below FRAME_COUNT, returns 0 when none is left
		function bit lowest_free(output int unsigned frame);
			frame = 0;
			for (int w = 0; w < WORD_COUNT; w++) begin
				if (used_words[w] == '1)
					continue;
				for (int b = 0; b < WORD_BITS; b++) begin
					if (w * WORD_BITS + b >= FRAME_COUNT)
						return 0;
					if (!used_words[w][b]) begin
						frame = w * WORD_BITS + b;
						return 1;
					end
				end
			end
			return 0;
		endfunction

		// Apply one request to the mirror and build its result
		function pfba_pkg::rsp_t predict_response(pfba_pkg::req_t r);
			pfba_pkg::rsp_t x;
			int unsigned fn;
			int unsigned f;
			bit in_range;
			x = '0;
			x.status = pfba_pkg::STAT_DONE;
			fn = 32'(r.frame_number);
			in_range = fn < FRAME_COUNT;
			case (r.command)
				pfba_pkg::CMD_ALLOC: begin
					if (r.page_present)
						x.status = pfba_pkg::STAT_SKIP;
					else if (!lowest_free(f))
						x.status = pfba_pkg::STAT_NOFREE;
					else begin
						used_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
						x.result_frame   = f[pfba_pkg::FRAME_NUM_W-1:0];
						x.entry_present  = 1'b1;
						x.entry_writable = r.writable;
						x.entry_user     = !r.kernel;
					end
				end
				pfba_pkg::CMD_FREE: begin
					if (fn == 0 || !in_range)
						x.status = pfba_pkg::STAT_SKIP;
					else
						used_words[fn / WORD_BITS][fn % WORD_BITS] = 1'b0;
				end
				pfba_pkg::CMD_CLAIM: begin
					if (!in_range)
						x.status = pfba_pkg::STAT_SKIP;
					else begin
						used_words[fn / WORD_BITS][fn % WORD_BITS] = 1'b1;
						x.result_frame   = r.frame_number;
						x.entry_present  = 1'b1;
						x.entry_writable = r.writable;
						x.entry_user     = !r.kernel;
					end
				end
				default: begin
					if (!in_range)
						x.status = pfba_pkg::STAT_SKIP;
					else
						x.frame_busy = used_words[fn / WORD_BITS][fn % WORD_BITS];
				end
			endcase
			return x;
		endfunction

		// Accepted request: queue its expected result, remember handed-out frames
		function void note_request(pfba_pkg::req_t r);
			pfba_pkg::rsp_t x;
			x = predict_response(r);
			expected_results.push_back(x);
			if (x.entry_present) begin
				granted_frames.push_back(32'(x.result_frame));
				if (granted_frames.size() > 24)
					void'(granted_frames.pop_front());
			end
		endfunction

		function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Strobed result: compare against the oldest pending expectation
		function void check_result(pfba_pkg::rsp_t got);
			pfba_pkg::rsp_t x;
			if (expected_results.size() == 0) begin
				$error("result with nothing pending: frame %0d status %0d",
					got.result_frame, got.status);
				errors++;
				return;
			end
			x = expected_results.pop_front();
			check_field("result_frame", 32'(x.result_frame), 32'(got.result_frame));
			check_field("entry_present", 32'(x.entry_present), 32'(got.entry_present));
			check_field("entry_writable", 32'(x.entry_writable), 32'(got.entry_writable));
			check_field("entry_user", 32'(x.entry_user), 32'(got.entry_user));
			check_field("frame_busy", 32'(x.frame_busy), 32'(got.frame_busy));
			check_field("status", 32'(x.status), 32'(got.status));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	pfba_pkg::req_t req;
	logic done;
	pfba_pkg::rsp_t rsp;

	frame_ledger ledger;
	int unsigned stall_cycles;
	int unsigned burst_left;

	page_frame_bitmap_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Monitor: results first, then new transfers; watchdog on quiet cycles
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				ledger.check_result(rsp);
				moved = 1'b1;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				ledger.note_request(req);
				moved = 1'b1;
			end
			if (moved)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic pfba_pkg::req_t make_req(pfba_pkg::cmd_t c, int unsigned fn,
		bit p, bit k, bit w);
		pfba_pkg::req_t r;
		r.command      = c;
		r.frame_number = fn[pfba_pkg::FRAME_NUM_W-1:0];
		r.page_present = p;
		r.kernel       = k;
		r.writable     = w;
		return r;
	endfunction

	// Random request: mostly a small frame window and recently granted frames
	function automatic pfba_pkg::req_t random_request();
		int unsigned pick;
		int unsigned fn;
		pfba_pkg::cmd_t c;
		bit p;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			fn = $urandom();
		else if (pick < 45 && ledger.granted_frames.size() > 0)
			fn = ledger.granted_frames[$urandom_range(0, ledger.granted_frames.size() - 1)];
		else
			fn = $urandom_range(0, 191);
		pick = $urandom_range(0, 99);
		if (pick < 35)
			c = pfba_pkg::CMD_ALLOC;
		else if (pick < 55)
			c = pfba_pkg::CMD_FREE;
		else if (pick < 75)
			c = pfba_pkg::CMD_CLAIM;
		else
			c = pfba_pkg::CMD_TEST;
		if (c == pfba_pkg::CMD_ALLOC)
			p = ($urandom_range(0, 9) == 0);
		else
			p = 1'($urandom_range(0, 1));
		return make_req(c, fn, p, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	// Drive one request and hold it until the transfer; paced adds burst gaps
	task automatic transfer_request(pfba_pkg::req_t r, bit paced);
		int unsigned gap;
		if (paced) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
				start <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
			end
			burst_left--;
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	initial begin
		pfba_pkg::req_t plan[$];
		ledger       = new();
		stall_cycles = 0;
		burst_left   = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pass on an empty bitmap
		plan.push_back(make_req(pfba_pkg::CMD_TEST, 0, 1'b0, 1'b0, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_ALLOC, 65535, 1'b0, 1'b0, 1'b1));
		// page already present
		plan.push_back(make_req(pfba_pkg::CMD_ALLOC, 0, 1'b1, 1'b1, 1'b1));
		plan.push_back(make_req(pfba_pkg::CMD_ALLOC, 0, 1'b0, 1'b1, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_TEST, 1, 1'b1, 1'b1, 1'b1));
		// frame zero is kept
		plan.push_back(make_req(pfba_pkg::CMD_FREE, 0, 1'b0, 1'b0, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_FREE, 1, 1'b0, 1'b0, 1'b0));
		// already free
		plan.push_back(make_req(pfba_pkg::CMD_FREE, 1, 1'b1, 1'b1, 1'b1));
		plan.push_back(make_req(pfba_pkg::CMD_TEST, 1, 1'b0, 1'b0, 1'b0));
		// already used
		plan.push_back(make_req(pfba_pkg::CMD_CLAIM, 0, 1'b0, 1'b0, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_CLAIM, 65535, 1'b1, 1'b1, 1'b1));
		plan.push_back(make_req(pfba_pkg::CMD_TEST, 65535, 1'b0, 1'b0, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_CLAIM, 31, 1'b0, 1'b0, 1'b1));
		plan.push_back(make_req(pfba_pkg::CMD_CLAIM, 32, 1'b0, 1'b1, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_ALLOC, 0, 1'b0, 1'b0, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_CLAIM, 21845, 1'b0, 1'b0, 1'b1));
		plan.push_back(make_req(pfba_pkg::CMD_TEST, 43690, 1'b1, 1'b1, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_FREE, 65535, 1'b0, 1'b0, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_TEST, 65535, 1'b0, 1'b0, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_FREE, 32767, 1'b0, 1'b1, 1'b1));
		plan.push_back(make_req(pfba_pkg::CMD_TEST, 21845, 1'b0, 1'b0, 1'b0));
		plan.push_back(make_req(pfba_pkg::CMD_ALLOC, 43690, 1'b0, 1'b1, 1'b1));
		foreach (plan[i])
			transfer_request(plan[i], 1'b1);

		// Random traffic
		repeat (RANDOM_ITEMS)
			transfer_request(random_request(), 1'b1);
		start <= 1'b0;

		// Drain, then watch a while for stray results
		while (ledger.expected_results.size() != 0)
			@(posedge clk);
		repeat (WORD_COUNT + 8) @(posedge clk);
		if (ledger.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pfba_pkg.sv
rtl/core/pfba_ctrl.sv
rtl/core/pfba_dpath.sv
rtl/core/page_frame_bitmap_allocator.sv
tb/sv/testbench.sv
